@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, held off while in reset
`define BFN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check, also active during reset
`define BFN_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/bfn_pkg.sv @@
`timescale 1ns / 1ps

package bfn_pkg;

  localparam int IN_W    = 192;
  localparam int FIELD_W = 64;
  localparam int OUT_W   = 72;
  localparam int NUM_W   = 42;
  localparam int DEN_W   = 20;
  localparam int COMP_W  = 20;
  localparam int STAT_W  = 3;
  localparam int SHIFT_W = 5;
  localparam int CNT_W   = $clog2(NUM_W);
  localparam int SCALE_SHIFT = 2;
  localparam logic [FIELD_W-1:0] MAX_COMPONENT = 64'd1000000;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_NEG_WHOLE = 3'd1,
    ST_BAD_DEN   = 3'd2,
    ST_NUM_RANGE = 3'd3,
    ST_TOO_LARGE = 3'd4
  } status_t;

  typedef struct packed {
    status_t           status;
    logic [COMP_W-1:0] whole;
    logic [COMP_W-1:0] num;
    logic [COMP_W-1:0] den;
  } bfn_req_t;

  typedef struct packed {
    status_t          status;
    logic [DEN_W-1:0] rd;
    logic [NUM_W-1:0] rn;
  } bfn_res_t;

endpackage

@@ sv/bfn_alu.sv @@
`timescale 1ns / 1ps

module bfn_alu import bfn_pkg::*; (
  input  logic [NUM_W-1:0] x,
  input  logic [NUM_W-1:0] y,
  output logic [NUM_W-1:0] diff,
  output logic             ge
);

  logic [NUM_W:0] wide;

  assign wide = {1'b0, x} - {1'b0, y};
  assign diff = wide[NUM_W-1:0];
  assign ge   = ~wide[NUM_W];

endmodule

@@ sv/bfn_seq.sv @@
`timescale 1ns / 1ps

module bfn_seq import bfn_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  bfn_req_t req,
  output logic     idle,
  output logic     res_valid,
  input  logic     res_take,
  output bfn_res_t res
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_LOAD, S_GCD, S_DIVN, S_DIVD, S_DONE
  } state_t;

  state_t                   state;
  logic [COMP_W-1:0]        whole_r;
  logic [COMP_W-1:0]        num_r;
  logic [COMP_W-1:0]        den_r;
  logic [2*COMP_W-1:0]      prod;
  logic [NUM_W-1:0]         n_r;
  logic [NUM_W-1:0]         a;
  logic [DEN_W-1:0]         b;
  logic [SHIFT_W-1:0]       k;
  logic [DEN_W-1:0]         g;
  logic [NUM_W-1:0]         dvd;
  logic [DEN_W-1:0]         rem;
  logic [CNT_W-1:0]         cnt;

  logic [NUM_W-1:0] alu_x;
  logic [NUM_W-1:0] alu_y;
  logic [NUM_W-1:0] alu_diff;
  logic             alu_ge;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W-1:0] rem_next;
  logic [NUM_W-1:0] dvd_next;
  logic             last_step;

  bfn_alu u_alu (
    .x    (alu_x),
    .y    (alu_y),
    .diff (alu_diff),
    .ge   (alu_ge)
  );

  always_comb begin
    rem_sh = {rem, dvd[NUM_W-1]};
    if (state == S_GCD) begin
      alu_x = a;
      alu_y = {{(NUM_W-DEN_W){1'b0}}, b};
    end else begin
      alu_x = {{(NUM_W-DEN_W-1){1'b0}}, rem_sh};
      alu_y = {{(NUM_W-DEN_W){1'b0}}, g};
    end
    rem_next  = alu_ge ? alu_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    dvd_next  = {dvd[NUM_W-2:0], alu_ge};
    last_step = (cnt == CNT_W'(NUM_W - 1));
  end

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            whole_r    <= req.whole;
            num_r      <= req.num;
            den_r      <= req.den;
            res.status <= req.status;
            res.rn     <= '0;
            res.rd     <= '0;
            state      <= (req.status == ST_OK) ? S_MUL : S_DONE;
          end
        end
        S_MUL: begin
          prod  <= whole_r * den_r;
          state <= S_LOAD;
        end
        S_LOAD: begin
          n_r   <= {prod, SCALE_SHIFT'(0)}
                   + {{(NUM_W-COMP_W-SCALE_SHIFT){1'b0}}, num_r, SCALE_SHIFT'(0)};
          a     <= {prod, SCALE_SHIFT'(0)}
                   + {{(NUM_W-COMP_W-SCALE_SHIFT){1'b0}}, num_r, SCALE_SHIFT'(0)};
          b     <= den_r;
          k     <= '0;
          state <= S_GCD;
        end
        S_GCD: begin
          priority if (a == '0) begin
            g     <= b << k;
            dvd   <= n_r;
            rem   <= '0;
            cnt   <= '0;
            state <= S_DIVN;
          end else if (!a[0] && !b[0]) begin
            a <= a >> 1;
            b <= b >> 1;
            k <= k + 1'b1;
          end else if (!a[0]) begin
            a <= a >> 1;
          end else if (!b[0]) begin
            b <= b >> 1;
          end else if (alu_ge) begin
            a <= alu_diff >> 1;
          end else begin
            // a < b, both odd: swap and subtract next cycle
            a <= {{(NUM_W-DEN_W){1'b0}}, b};
            b <= a[DEN_W-1:0];
          end
        end
        S_DIVN: begin
          if (last_step) begin
            res.rn <= dvd_next;
            dvd    <= {{(NUM_W-COMP_W){1'b0}}, den_r};
            rem    <= '0;
            cnt    <= '0;
            state  <= S_DIVD;
          end else begin
            rem <= rem_next;
            cnt <= cnt + 1'b1;
            dvd <= dvd_next;
          end
        end
        S_DIVD: begin
          rem <= rem_next;
          dvd <= dvd_next;
          cnt <= cnt + 1'b1;
          if (last_step) begin
            res.rd <= dvd_next[DEN_W-1:0];
            state  <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/beat_fraction_normalizer.sv @@
// Invalid tuples go straight to the result; valid tuples pass through multiply,
// scale and add, binary GCD, then two 42-step restoring divisions, with GCD and
// divisions on one shared subtractor.
// One request in flight: the next is taken only once the result moves to the
// output register.
// Reset (rst, synchronous, active high) returns to idle and drops m_tvalid.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module beat_fraction_normalizer import bfn_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // whole_count [63:0], part_numerator [127:64], part_denominator [191:128]
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // reduced_numerator [41:0], reduced_denominator [61:42], status [64:62], zero pad
  output logic [OUT_W-1:0] m_tdata
);

  logic [FIELD_W-1:0] whole;
  logic [FIELD_W-1:0] num;
  logic [FIELD_W-1:0] den;
  bfn_req_t           req;
  bfn_res_t           res;
  logic               seq_idle;
  logic               res_valid;
  logic               res_take;
  logic [STAT_W-1:0]  out_status;
  logic               out_err;
  logic               out_good;
  logic [NUM_W+DEN_W-1:0] out_frac;
  logic [DEN_W-1:0]   out_rd;

  assign whole = s_tdata[FIELD_W-1:0];
  assign num   = s_tdata[2*FIELD_W-1:FIELD_W];
  assign den   = s_tdata[3*FIELD_W-1:2*FIELD_W];

  always_comb begin
    req.whole = whole[COMP_W-1:0];
    req.num   = num[COMP_W-1:0];
    req.den   = den[COMP_W-1:0];
    priority if (whole[FIELD_W-1]) begin
      req.status = ST_NEG_WHOLE;
    end else if (den[FIELD_W-1] || den == '0) begin
      req.status = ST_BAD_DEN;
    end else if (num[FIELD_W-1] || num >= den) begin
      req.status = ST_NUM_RANGE;
    end else if (whole > MAX_COMPONENT || num > MAX_COMPONENT || den > MAX_COMPONENT) begin
      req.status = ST_TOO_LARGE;
    end else begin
      req.status = ST_OK;
    end
  end

  assign s_tready = seq_idle;
  assign res_take = res_valid && (!m_tvalid || m_tready);

  bfn_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_tvalid && s_tready),
    .req       (req),
    .idle      (seq_idle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      m_tdata <= {(OUT_W-STAT_W-DEN_W-NUM_W)'(0), res.status, res.rd, res.rn};
    end
  end

  assign out_status = m_tdata[NUM_W+DEN_W+STAT_W-1:NUM_W+DEN_W];
  assign out_err    = m_tvalid && (out_status != ST_OK);
  assign out_good   = m_tvalid && (out_status == ST_OK);
  assign out_frac   = m_tdata[NUM_W+DEN_W-1:0];
  assign out_rd     = m_tdata[NUM_W+DEN_W-1:NUM_W];

  `BFN_ASSERT(a_busy_after_req, s_tvalid && s_tready |=> !s_tready, "accepted request while busy")
  `BFN_ASSERT(a_err_zero, out_err |-> out_frac == '0, "error result carries nonzero fraction")
  `BFN_ASSERT(a_ok_den, out_good |-> out_rd != '0, "good result with zero denominator")
  `BFN_ASSERT_ALWAYS(a_rst_idle, rst |=> !m_tvalid && s_tready, "not idle after reset")

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import bfn_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [63:0] BEAT_SCALE = 64'd4;
  localparam int unsigned LIMIT_INT = 1000000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  // whole_count [63:0], part_numerator [127:64], part_denominator [191:128]
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  // reduced_numerator [41:0], reduced_denominator [61:42], status [64:62], zero pad
  logic [OUT_W-1:0] m_tdata;

  bfn_res_t expected_beats[$];
  bfn_res_t want;
  int       error_count = 0;
  int       cycle_count = 0;
  bit       tx_idle_en = 1'b1;
  bit       rx_idle_en = 1'b1;
  int       rx_hold_len = 0;
  int       rx_hold_tag = 0;
  int       rx_hold_seen = 0;
  int       rx_hold_left = 0;

  beat_fraction_normalizer i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // checks run in order: negative whole, bad denominator, numerator range, size
  function automatic bfn_res_t normalize_beat(logic [63:0] whole, logic [63:0] num,
                                              logic [63:0] den);
    bfn_res_t r;
    longint unsigned total, a, b, t;
    r = '0;
    if (whole[63]) begin
      r.status = ST_NEG_WHOLE;
    end else if (den[63] || den == 64'd0) begin
      r.status = ST_BAD_DEN;
    end else if (num[63] || num >= den) begin
      r.status = ST_NUM_RANGE;
    end else if (whole > MAX_COMPONENT || num > MAX_COMPONENT || den > MAX_COMPONENT) begin
      r.status = ST_TOO_LARGE;
    end else begin
      total = whole * BEAT_SCALE * den + num * BEAT_SCALE;
      a = total;
      b = den;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      if (a == 0) a = 1;
      r.status = ST_OK;
      r.rn = NUM_W'(total / a);
      r.rd = DEN_W'(den / a);
    end
    return r;
  endfunction

  task automatic drive_beat(input logic [63:0] whole, input logic [63:0] num,
                            input logic [63:0] den);
    while (tx_idle_en && $urandom_range(0, 99) < 34) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {den, num, whole};
    do @(posedge clk); while (!s_tready);
    expected_beats.insert(expected_beats.size(), normalize_beat(whole, num, den));
  endtask

  task automatic wait_all_beats_out();
    s_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  // biased toward small values, the limit and values just under it
  function automatic logic [63:0] pick_component(int unsigned hi);
    case ($urandom_range(0, 3))
      0: return 64'($urandom_range(0, (hi < 15) ? hi : 15));
      1: return 64'($urandom_range(0, (hi < 1000) ? hi : 1000));
      2: return 64'($urandom_range(0, hi));
      default: return 64'(hi - $urandom_range(0, (hi < 7) ? hi : 7));
    endcase
  endfunction

  task automatic drive_valid_beat();
    logic [63:0] den;
    den = pick_component(LIMIT_INT - 1) + 64'd1;
    drive_beat(pick_component(LIMIT_INT), pick_component(int'(den) - 1), den);
  endtask

  task automatic drive_noise_beat();
    logic [63:0] w, n, d;
    w = {$urandom, $urandom};
    n = {$urandom, $urandom};
    d = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: ;
      1: w[63] = 1'b0;
      2: begin
        w = pick_component(LIMIT_INT);
        if ($urandom_range(0, 1)) d = 64'd0;
      end
      3: begin
        w = pick_component(LIMIT_INT);
        d = pick_component(LIMIT_INT - 1) + 64'd1;
        n = $urandom_range(0, 1) ? d : n;
      end
      4: begin
        w = 64'(LIMIT_INT) + 64'($urandom_range(1, 3));
        d = pick_component(LIMIT_INT - 1) + 64'd1;
        n = pick_component(int'(d) - 1);
      end
      default: begin
        w = pick_component(LIMIT_INT);
        d = {1'b0, $urandom_range(0, 1) ? 31'($urandom) : 31'd0, $urandom} + 64'(LIMIT_INT);
        n = d - 64'($urandom_range(1, 5));
      end
    endcase
    drive_beat(w, n, d);
  endtask

  task automatic test_error_codes();
    drive_beat(64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'd1);
    drive_beat(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0);
    drive_beat(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    drive_beat(64'd0, 64'd0, 64'd0);
    drive_beat(64'd1, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    drive_beat(64'd2, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
    drive_beat(64'd3, 64'hFFFF_FFFF_FFFF_FFFF, 64'd5);
    drive_beat(64'd3, 64'd5, 64'd5);
    drive_beat(64'd0, 64'h7FFF_FFFF_FFFF_FFFF, 64'd7);
    drive_beat(64'd1000001, 64'd0, 64'd1);
    drive_beat(64'h7FFF_FFFF_FFFF_FFFF, 64'd0, 64'd1);
    drive_beat(64'd0, 64'd1000000, 64'd1000001);
    drive_beat(64'd0, 64'd0, 64'h7FFF_FFFF_FFFF_FFFF);
    wait_all_beats_out();
  endtask

  task automatic test_exact_fractions();
    drive_beat(64'd0, 64'd0, 64'd1);
    drive_beat(64'd0, 64'd0, 64'd1000000);
    drive_beat(64'd1000000, 64'd999999, 64'd1000000);
    drive_beat(64'd1000000, 64'd0, 64'd1);
    drive_beat(64'd0, 64'd1, 64'd3);
    drive_beat(64'd7, 64'd2, 64'd4);
    drive_beat(64'd0, 64'd999999, 64'd1000000);
    drive_beat(64'd5, 64'd524287, 64'd524288);
    drive_beat(64'd1000000, 64'd999982, 64'd999983);
    wait_all_beats_out();
  endtask

  task automatic test_random_beats(input int count);
    repeat (count) begin
      if ($urandom_range(0, 99) < 75) drive_valid_beat();
      else drive_noise_beat();
    end
    wait_all_beats_out();
  endtask

  task automatic test_back_to_back(input int count);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (count) drive_valid_beat();
    wait_all_beats_out();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_output_stall(input int count);
    tx_idle_en = 1'b0;
    rx_hold_len = 600;
    rx_hold_tag <= rx_hold_tag + 1;
    repeat (count) begin
      if ($urandom_range(0, 3) == 0) drive_noise_beat();
      else drive_valid_beat();
    end
    wait_all_beats_out();
    tx_idle_en = 1'b1;
  endtask

  // receiver: random idling, plus a hold-off when a test asks for one
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (rx_hold_tag != rx_hold_seen) begin
      rx_hold_seen <= rx_hold_tag;
      rx_hold_left <= rx_hold_len;
      m_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= rx_idle_en ? ($urandom_range(0, 99) >= 34) : 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_beats.size() == 0) begin
        error_count++;
        $display("%0t: result with no request pending: %h", $time, m_tdata);
      end else begin
        want = expected_beats.pop_front();
        if (m_tdata[NUM_W-1:0] !== want.rn) begin
          error_count++;
          $display("%0t: reduced_numerator expected %0d actual %0d", $time, want.rn,
                   m_tdata[NUM_W-1:0]);
        end
        if (m_tdata[NUM_W+DEN_W-1:NUM_W] !== want.rd) begin
          error_count++;
          $display("%0t: reduced_denominator expected %0d actual %0d", $time, want.rd,
                   m_tdata[NUM_W+DEN_W-1:NUM_W]);
        end
        if (m_tdata[NUM_W+DEN_W+STAT_W-1:NUM_W+DEN_W] !== want.status) begin
          error_count++;
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   m_tdata[NUM_W+DEN_W+STAT_W-1:NUM_W+DEN_W]);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL beat_fraction_normalizer");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_error_codes();
    test_exact_fractions();
    test_random_beats(250);
    test_output_stall(20);
    test_back_to_back(120);
    test_random_beats(250);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS beat_fraction_normalizer");
    end else begin
      $display("FAIL beat_fraction_normalizer");
    end
    $finish;
  end

endmodule
